// ===== rtl/dts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_pkg
// Shared constants and types for the discrete table sampler.
// ----------------------------------------------------------------------------
package dts_pkg;

   localparam int MAX_OUTCOMES = 256;
   localparam int TABLE_DEPTH  = 65536;
   localparam int FIRST_DEPTH  = 256;

   localparam int ENTRY_W  = 8;
   localparam int DIGIT_W  = 8;
   localparam int WORD_W   = 32;
   localparam int ADDR_W   = $clog2(TABLE_DEPTH);
   localparam int FADDR_W  = $clog2(FIRST_DEPTH);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int LOADED_W = $clog2(MAX_OUTCOMES) + 1;
   localparam int TH_W     = WORD_W + 3;

   localparam int SHIFT_FIRST  = 24;
   localparam int SHIFT_SECOND = 32 - 8 * 2;
   localparam int SHIFT_THIRD  = 32 - 8 * 3;

   typedef logic [ENTRY_W-1:0]  entry_type;
   typedef logic [DIGIT_W-1:0]  digit_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [FADDR_W-1:0]  faddr_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [LOADED_W-1:0] loaded_type;
   typedef logic [TH_W-1:0]     th_type;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_CLEAR  = 2'd0;
   localparam req_code_type REQ_LOAD   = 2'd1;
   localparam req_code_type REQ_SAMPLE = 2'd2;
   localparam req_code_type REQ_NONE   = 2'd3;

   typedef logic [1:0] tbl_type;
   localparam tbl_type TBL_FIRST  = 2'd0;
   localparam tbl_type TBL_SECOND = 2'd1;
   localparam tbl_type TBL_THIRD  = 2'd2;
   localparam tbl_type TBL_FOURTH = 2'd3;

   typedef struct packed {
      tbl_type   sel;
      logic      hit;
      faddr_type first_addr;
      addr_type  addr;
   } pick_type;

endpackage
`default_nettype wire

// ===== rtl/dts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dts_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/dts_select.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dts_select
// Maps a random word onto a table and slot using the cumulative thresholds.
// ----------------------------------------------------------------------------
module dts_select (
   input  wire dts_pkg::word_type random_word,
   input  wire dts_pkg::th_type   thresh0,
   input  wire dts_pkg::th_type   thresh1,
   input  wire dts_pkg::th_type   thresh2,
   input  wire dts_pkg::cnt_type  fourth_count,
   output      dts_pkg::pick_type pick
);

   dts_pkg::th_type r_wide;
   dts_pkg::th_type diff1;
   dts_pkg::th_type diff2;
   dts_pkg::th_type diff3;

   always_comb begin
      r_wide = dts_pkg::th_type'(random_word);
      diff1  = r_wide - thresh0;
      diff2  = r_wide - thresh1;
      diff3  = r_wide - thresh2;

      pick.first_addr = random_word[dts_pkg::SHIFT_FIRST +: dts_pkg::FADDR_W];
      pick.hit        = 1'b1;
      priority if (r_wide < thresh0) begin
         pick.sel  = dts_pkg::TBL_FIRST;
         pick.addr = diff1[dts_pkg::ADDR_W-1:0];
      end else if (r_wide < thresh1) begin
         pick.sel  = dts_pkg::TBL_SECOND;
         pick.addr = diff1[dts_pkg::SHIFT_SECOND +: dts_pkg::ADDR_W];
      end else if (r_wide < thresh2) begin
         pick.sel  = dts_pkg::TBL_THIRD;
         pick.addr = diff2[dts_pkg::SHIFT_THIRD +: dts_pkg::ADDR_W];
      end else begin
         pick.sel  = dts_pkg::TBL_FOURTH;
         pick.addr = diff3[dts_pkg::ADDR_W-1:0];
         // slots past the fill read as outcome zero
         pick.hit  = diff3 < dts_pkg::th_type'(fourth_count);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/discrete_table_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// discrete_table_sampler
// Condensed-table discrete sampler with four base-256 digit tables.
// ----------------------------------------------------------------------------
// Sample, clear and unknown requests are taken one per cycle unless a load
// is in progress or the response side stalls; a sample's word is registered
// by the table RAM read, then by the output register. A load holds the input
// while it walks its weight's largest base-256 digit: the four table RAMs are
// filled in parallel, one entry per table per cycle, then the fill counts and
// the three cumulative thresholds are updated before the status word is issued.
// A refused load answers with status set and outcome zero. Table contents are
// not cleared; slots beyond a table's fill count read as outcome zero.
module discrete_table_sampler (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [1:0]        req_type,
   input  wire logic [31:0]       req_weight,
   input  wire logic [31:0]       req_random_word,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_outcome,
   output      logic              rsp_status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_COUNT = 3'd2;
   localparam logic [2:0] ST_THR1  = 3'd3;
   localparam logic [2:0] ST_THR2  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   dts_pkg::cnt_type    cnt_ff [4];
   dts_pkg::cnt_type    cnt_in [4];
   dts_pkg::loaded_type loaded_ff, loaded_in;
   dts_pkg::th_type     th0_ff, th0_in, th1_ff, th1_in, th2_ff, th2_in;
   dts_pkg::digit_type  dig_ff [4];
   dts_pkg::digit_type  dig_in [4];
   dts_pkg::digit_type  walk_ff, walk_in;
   dts_pkg::entry_type  id_ff, id_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_sample_ff, s1_sample_in;
   logic             s1_hit_ff, s1_hit_in;
   logic             s1_status_ff, s1_status_in;
   dts_pkg::tbl_type s1_sel_ff, s1_sel_in;

   logic               rsp_valid_ff, rsp_valid_in;
   dts_pkg::entry_type rsp_outcome_ff, rsp_outcome_in;
   logic               rsp_status_ff, rsp_status_in;

   dts_pkg::digit_type req_dig [4];
   dts_pkg::cnt_type   cap [4];
   dts_pkg::cnt_type   wr_sum [4];
   dts_pkg::entry_type rd_data [4];
   logic               wr_en [4];
   logic [dts_pkg::DIGIT_W:0] walk_next;
   logic               refuse;
   logic               accept;
   logic               advance;
   logic               s1_free;
   logic               walk_more;
   dts_pkg::pick_type  pick;

   assign req_dig[0] = req_weight[dts_pkg::SHIFT_FIRST +: dts_pkg::DIGIT_W];
   assign req_dig[1] = req_weight[dts_pkg::SHIFT_SECOND +: dts_pkg::DIGIT_W];
   assign req_dig[2] = req_weight[dts_pkg::SHIFT_THIRD +: dts_pkg::DIGIT_W];
   assign req_dig[3] = req_weight[dts_pkg::DIGIT_W-1:0];

   assign cap[0] = dts_pkg::cnt_type'(dts_pkg::FIRST_DEPTH);
   assign cap[1] = dts_pkg::cnt_type'(dts_pkg::TABLE_DEPTH);
   assign cap[2] = dts_pkg::cnt_type'(dts_pkg::TABLE_DEPTH);
   assign cap[3] = dts_pkg::cnt_type'(dts_pkg::TABLE_DEPTH);

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free   = !s1_valid_ff || advance;
   assign req_ready = (state_ff == ST_IDLE) && s1_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      refuse = loaded_ff >= dts_pkg::loaded_type'(dts_pkg::MAX_OUTCOMES);
      for (int k = 0; k < 4; k++) begin
         if (cnt_ff[k] + dts_pkg::cnt_type'(req_dig[k]) > cap[k]) begin
            refuse = 1'b1;
         end
      end
   end

   dts_select u_select (
      .random_word  (req_random_word),
      .thresh0      (th0_ff),
      .thresh1      (th1_ff),
      .thresh2      (th2_ff),
      .fourth_count (cnt_ff[3]),
      .pick         (pick)
   );

   // table fill: all four tables written side by side
   assign walk_next = {1'b0, walk_ff} + 1'b1;
   always_comb begin
      walk_more = 1'b0;
      for (int k = 0; k < 4; k++) begin
         wr_en[k]  = (state_ff == ST_WALK) && (walk_ff < dig_ff[k]);
         wr_sum[k] = cnt_ff[k] + dts_pkg::cnt_type'(walk_ff);
         if (walk_next < {1'b0, dig_ff[k]}) begin
            walk_more = 1'b1;
         end
      end
   end

   dts_ram #(.DEPTH(dts_pkg::FIRST_DEPTH), .WIDTH(dts_pkg::ENTRY_W)) u_first (
      .clock   (clock),
      .wr_en   (wr_en[0]),
      .wr_addr (wr_sum[0][dts_pkg::FADDR_W-1:0]),
      .wr_data (id_ff),
      .rd_en   (accept),
      .rd_addr (pick.first_addr),
      .rd_data (rd_data[0])
   );

   for (genvar g = 1; g < 4; g++) begin : g_tbl
      dts_ram #(.DEPTH(dts_pkg::TABLE_DEPTH), .WIDTH(dts_pkg::ENTRY_W)) u_tbl (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_sum[g][dts_pkg::ADDR_W-1:0]),
         .wr_data (id_ff),
         .rd_en   (accept),
         .rd_addr (pick.addr),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      th0_in       = th0_ff;
      th1_in       = th1_ff;
      th2_in       = th2_ff;
      walk_in      = walk_ff;
      id_in        = id_ff;
      for (int k = 0; k < 4; k++) begin
         cnt_in[k] = cnt_ff[k];
         dig_in[k] = dig_ff[k];
      end

      s1_valid_in  = s1_valid_ff && !advance;
      s1_sample_in = s1_sample_ff;
      s1_hit_in    = s1_hit_ff;
      s1_status_in = s1_status_ff;
      s1_sel_in    = s1_sel_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s1_valid_in  = 1'b1;
               s1_sample_in = 1'b0;
               s1_hit_in    = pick.hit;
               s1_status_in = 1'b0;
               s1_sel_in    = pick.sel;
               unique case (req_type)
                  dts_pkg::REQ_CLEAR: begin
                     loaded_in = '0;
                     th0_in    = '0;
                     th1_in    = '0;
                     th2_in    = '0;
                     for (int k = 0; k < 4; k++) begin
                        cnt_in[k] = '0;
                     end
                  end
                  dts_pkg::REQ_LOAD: begin
                     if (refuse) begin
                        s1_status_in = 1'b1;
                     end else begin
                        s1_valid_in = 1'b0;
                        walk_in     = '0;
                        id_in       = dts_pkg::entry_type'(loaded_ff);
                        for (int k = 0; k < 4; k++) begin
                           dig_in[k] = req_dig[k];
                        end
                        state_in = ST_WALK;
                     end
                  end
                  dts_pkg::REQ_SAMPLE: begin
                     s1_sample_in = 1'b1;
                  end
                  dts_pkg::REQ_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            walk_in = walk_next[dts_pkg::DIGIT_W-1:0];
            if (!walk_more) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            for (int k = 0; k < 4; k++) begin
               cnt_in[k] = cnt_ff[k] + dts_pkg::cnt_type'(dig_ff[k]);
            end
            loaded_in = loaded_ff + 1'b1;
            state_in  = ST_THR1;
         end
         ST_THR1: begin
            th0_in   = dts_pkg::th_type'(cnt_ff[0]) << dts_pkg::SHIFT_FIRST;
            th1_in   = (dts_pkg::th_type'(cnt_ff[0]) << dts_pkg::SHIFT_FIRST)
                     + (dts_pkg::th_type'(cnt_ff[1]) << dts_pkg::SHIFT_SECOND);
            state_in = ST_THR2;
         end
         ST_THR2: begin
            th2_in   = th1_ff + (dts_pkg::th_type'(cnt_ff[2]) << dts_pkg::SHIFT_THIRD);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (s1_free) begin
               s1_valid_in  = 1'b1;
               s1_sample_in = 1'b0;
               s1_status_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_status_in  = rsp_status_ff;
      if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = s1_status_ff;
         rsp_outcome_in = (s1_sample_ff && s1_hit_ff) ? rd_data[s1_sel_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         th0_ff       <= '0;
         th1_ff       <= '0;
         th2_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         th0_ff       <= th0_in;
         th1_ff       <= th1_in;
         th2_ff       <= th2_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 4; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      id_ff          <= id_in;
      s1_sample_ff   <= s1_sample_in;
      s1_hit_ff      <= s1_hit_in;
      s1_status_ff   <= s1_status_in;
      s1_sel_ff      <= s1_sel_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_status_ff  <= rsp_status_in;
      for (int k = 0; k < 4; k++) begin
         dig_ff[k] <= dig_in[k];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_status  = rsp_status_ff;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the discrete table sampler.
// A table of directed words runs first: reset, extremes, full tables,
// zero weights, empty slots and unknown requests. Random sessions follow.
// They build distributions that sum to 2^32, including one with the full
// outcome count, and mix in broken loads and noise. Draws are aimed at
// all four digit tables. Each accepted request updates a shadow copy of
// the tables; each word is checked in order against it or a pinned answer.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      dts_pkg::entry_type outcome;
      logic               status;
   } answer_type;

   typedef struct packed {
      dts_pkg::req_code_type kind;
      dts_pkg::word_type     weight;
      dts_pkg::word_type     rword;
      logic                  pinned;
      dts_pkg::entry_type    outcome;
      logic                  status;
   } probe_type;

   localparam int N_PROBES = 24;
   localparam probe_type PROBES [N_PROBES] = '{
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'hFF00_0000, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'hFF00_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b1},
      '{dts_pkg::REQ_LOAD,   32'h00FF_FFFF, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'h0000_0001, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 8'd1, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFEFF_FFFF, 1'b1, 8'd1, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFF00_0000, 1'b1, 8'd2, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1, 8'd2, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'd3, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h5A5A_5A5A, 32'h1234_5678, 1'b0, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'hA5A5_A5A5, 32'hFFFF_80FF, 1'b0, 8'd0, 1'b0},
      '{dts_pkg::REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'h0100_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_SAMPLE, 32'h0000_0000, 32'hFF00_0000, 1'b1, 8'd1, 1'b0},
      '{dts_pkg::REQ_LOAD,   32'h0100_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b1},
      '{dts_pkg::REQ_NONE,   32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b0},
      '{dts_pkg::REQ_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, 8'd0, 1'b0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_type = dts_pkg::REQ_NONE;
   dts_pkg::word_type  req_weight = '0;
   dts_pkg::word_type  req_random_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   dts_pkg::entry_type rsp_outcome;
   logic               rsp_status;

   logic       pin_valid = 1'b0;
   answer_type pin_answer = '0;

   // shadow of the block state
   dts_pkg::entry_type  lut [4][dts_pkg::TABLE_DEPTH];
   dts_pkg::cnt_type    fill [4] = '{default: '0};
   dts_pkg::loaded_type outcomes_in = '0;

   answer_type answers_due [$];

   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int items_sent = 0;
   int n_errors = 0;
   int n_words = 0;
   int n_draws = 0;
   int n_loads = 0;
   int n_refused = 0;
   int n_clears = 0;
   int n_unknown = 0;
   int n_full = 0;

   discrete_table_sampler uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_weight      (req_weight),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_outcome     (rsp_outcome),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int table_room(int k);
      return (k == dts_pkg::TBL_FIRST) ? dts_pkg::FIRST_DEPTH : dts_pkg::TABLE_DEPTH;
   endfunction

   function automatic bit append_outcome(dts_pkg::word_type w);
      dts_pkg::digit_type d [4];
      int k;
      int j;
      for (k = 0; k < 4; k++)
         d[k] = dts_pkg::digit_type'(w >> (dts_pkg::SHIFT_FIRST - 8 * k));
      if (outcomes_in >= dts_pkg::MAX_OUTCOMES) return 1'b0;
      for (k = 0; k < 4; k++)
         if (int'(fill[k]) + int'(d[k]) > table_room(k)) return 1'b0;
      for (k = 0; k < 4; k++) begin
         for (j = 0; j < int'(d[k]); j++)
            lut[k][int'(fill[k]) + j] = dts_pkg::entry_type'(outcomes_in);
         fill[k] = fill[k] + dts_pkg::cnt_type'(d[k]);
      end
      outcomes_in = outcomes_in + 1'b1;
      return 1'b1;
   endfunction

   function automatic dts_pkg::entry_type draw_outcome(dts_pkg::word_type r);
      longint unsigned j, th0, th1, th2, slot;
      dts_pkg::tbl_type sel;
      j = r;
      th0 = longint'(fill[0]) << dts_pkg::SHIFT_FIRST;
      th1 = th0 + (longint'(fill[1]) << dts_pkg::SHIFT_SECOND);
      th2 = th1 + (longint'(fill[2]) << dts_pkg::SHIFT_THIRD);
      if (j < th0) begin
         sel = dts_pkg::TBL_FIRST;
         slot = j >> dts_pkg::SHIFT_FIRST;
      end else if (j < th1) begin
         sel = dts_pkg::TBL_SECOND;
         slot = (j - th0) >> dts_pkg::SHIFT_SECOND;
      end else if (j < th2) begin
         sel = dts_pkg::TBL_THIRD;
         slot = (j - th1) >> dts_pkg::SHIFT_THIRD;
      end else begin
         sel = dts_pkg::TBL_FOURTH;
         slot = j - th2;
      end
      // slots past the fill count answer zero
      if (slot >= longint'(fill[sel])) return '0;
      return lut[sel][slot];
   endfunction

   function automatic answer_type answer_request(dts_pkg::req_code_type kind,
                                                 dts_pkg::word_type w,
                                                 dts_pkg::word_type r);
      answer_type a;
      a = '0;
      case (kind)
         dts_pkg::REQ_CLEAR: begin
            fill = '{default: '0};
            outcomes_in = '0;
         end
         dts_pkg::REQ_LOAD: a.status = !append_outcome(w);
         dts_pkg::REQ_SAMPLE: a.outcome = draw_outcome(r);
         default: ;
      endcase
      return a;
   endfunction

   // random word aimed at one digit table's range, or an extreme or unaimed one
   function automatic dts_pkg::word_type aim_draw();
      longint unsigned bound [5];
      longint unsigned r;
      int k;
      bound[0] = 0;
      bound[1] = longint'(fill[0]) << dts_pkg::SHIFT_FIRST;
      bound[2] = bound[1] + (longint'(fill[1]) << dts_pkg::SHIFT_SECOND);
      bound[3] = bound[2] + (longint'(fill[2]) << dts_pkg::SHIFT_THIRD);
      bound[4] = bound[3] + longint'(fill[3]);
      k = $urandom_range(4);
      if (k == 4 || bound[k + 1] <= bound[k]) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
         endcase
      end
      r = bound[k] + (longint'($urandom) % (bound[k + 1] - bound[k]));
      if (r > 64'hFFFF_FFFF) return $urandom;
      return dts_pkg::word_type'(r);
   endfunction

   always @(posedge clock) begin
      answer_type got, want, shadow;
      rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got.outcome = rsp_outcome;
         got.status = rsp_status;
         if (answers_due.size() == 0) begin
            if (n_errors < 10)
               $display("%0t: unexpected word: outcome %0d status %0d",
                        $realtime, got.outcome, got.status);
            n_errors++;
         end else begin
            want = answers_due.pop_front();
            if (got.outcome !== want.outcome || got.status !== want.status) begin
               if (n_errors < 10)
                  $display("%0t: word %0d: outcome exp %0d got %0d, status exp %0d got %0d",
                           $realtime, n_words, want.outcome, got.outcome,
                           want.status, got.status);
               n_errors++;
            end
         end
         n_words++;
      end
      if (!reset && req_valid && req_ready) begin
         shadow = answer_request(req_type, req_weight, req_random_word);
         answers_due.push_back(pin_valid ? pin_answer : shadow);
         case (req_type)
            dts_pkg::REQ_CLEAR: n_clears++;
            dts_pkg::REQ_LOAD: begin
               n_loads++;
               if (shadow.status) n_refused++;
            end
            dts_pkg::REQ_SAMPLE: n_draws++;
            default: n_unknown++;
         endcase
      end
   end

   task automatic send_word(dts_pkg::req_code_type kind, dts_pkg::word_type w,
                            dts_pkg::word_type r, logic pinned, answer_type a);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_weight <= w;
      req_random_word <= r;
      pin_valid <= pinned;
      pin_answer <= a;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   // cut points on [0, 2^32) give weights that sum to 2^32 (2^32 - 1 for one outcome)
   task automatic build_distribution(int n);
      longint unsigned cuts [$];
      longint unsigned prev, w;
      int i;
      for (i = 0; i < n - 1; i++) cuts.push_back(longint'($urandom));
      cuts.sort();
      cuts.push_back(64'h1_0000_0000);
      prev = 0;
      for (i = 0; i < cuts.size(); i++) begin
         w = cuts[i] - prev;
         prev = cuts[i];
         if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
         send_word(dts_pkg::REQ_LOAD, dts_pkg::word_type'(w), $urandom, 1'b0, '0);
      end
      n_full++;
   endtask

   task automatic draw_or_noise();
      int p;
      p = $urandom_range(99);
      if (p < 92) send_word(dts_pkg::REQ_SAMPLE, $urandom, aim_draw(), 1'b0, '0);
      else if (p < 95) send_word(dts_pkg::REQ_NONE, $urandom, $urandom, 1'b0, '0);
      else if (p < 98) send_word(dts_pkg::REQ_LOAD, $urandom, $urandom, 1'b0, '0);
      else send_word(dts_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, '0);
   endtask

   task automatic run_session();
      dts_pkg::word_type w;
      int pick, n, i;
      pick = $urandom_range(99);
      if (pick < 65) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         send_word(dts_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, '0);
         build_distribution(n);
         n = $urandom_range(10, 50);
         for (i = 0; i < n; i++) draw_or_noise();
      end else if (pick < 85) begin
         if ($urandom_range(4) != 0)
            send_word(dts_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, '0);
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: w = $urandom;
               1: w = {8'($urandom_range(128, 255)), 24'($urandom)};
               2: w = '0;
               default: w = {8'h00, 24'($urandom)};
            endcase
            send_word(dts_pkg::REQ_LOAD, w, $urandom, 1'b0, '0);
         end
         for (i = 0; i < 20; i++) draw_or_noise();
      end else begin
         for (i = 0; i < 10; i++)
            send_word(dts_pkg::req_code_type'($urandom_range(3)), $urandom, $urandom,
                      1'b0, '0);
      end
   endtask

   task automatic max_outcomes_session();
      int i;
      send_word(dts_pkg::REQ_CLEAR, $urandom, $urandom, 1'b0, '0);
      build_distribution(dts_pkg::MAX_OUTCOMES);
      // outcome count exhausted: refused
      send_word(dts_pkg::REQ_LOAD, $urandom, $urandom, 1'b0, '0);
      for (i = 0; i < 30; i++)
         send_word(dts_pkg::REQ_SAMPLE, $urandom, aim_draw(), 1'b0, '0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int i;
      src_idle_pct = 25;
      sink_idle_pct = 69;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (i = 0; i < N_PROBES; i++)
         send_word(PROBES[i].kind, PROBES[i].weight, PROBES[i].rword, PROBES[i].pinned,
                   '{PROBES[i].outcome, PROBES[i].status});
      drain();
      while (items_sent < 420) run_session();
      src_idle_pct = 69;
      sink_idle_pct = 25;
      max_outcomes_session();
      while (items_sent < 800) run_session();
      drain();
      src_idle_pct = 0;
      sink_idle_pct = 0;
      while (items_sent < 1100) run_session();
      drain();
      repeat (20) @(posedge clock);
      if (answers_due.size() != 0) begin
         $display("%0d expected words never arrived", answers_due.size());
         n_errors++;
      end
      $display("Covered %0d requests: %0d draws, %0d loads (%0d refused), %0d clears, %0d unknown",
               items_sent, n_draws, n_loads, n_refused, n_clears, n_unknown);
      $display("%0d complete distributions built, %0d words checked, %0d mismatches",
               n_full, n_words, n_errors);
      if (n_errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d words outstanding", answers_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
